FILE: src/srp_pkg.sv
// Shared types and constants for the skyline rectangle packer.
// Depends on nothing; imported by srp_ctrl, srp_dpath and the top level.
package srp_pkg;

  localparam int MAX_ATLAS_WIDTH = 512;
  localparam int HEIGHT_BITS     = 16;

  // column address, column count, item, bound and result widths
  localparam int AW       = $clog2(MAX_ATLAS_WIDTH);
  localparam int XW       = AW + 1;
  localparam int CFG_AW_W = 10;
  localparam int BW_W     = 9;
  localparam int W_W      = BW_W + 1;
  localparam int BND_W    = ((XW > W_W) ? XW : W_W) + 2;
  localparam int POS_X_W  = 9;
  localparam int POS_Y_W  = 16;

  localparam logic [HEIGHT_BITS-1:0] HMAX = {HEIGHT_BITS{1'b1}};

  // configuration register indexes
  localparam logic REG_ATLAS_WIDTH = 1'b0;
  localparam logic REG_PAD_ENABLE  = 1'b1;

  // input command codes
  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef logic [HEIGHT_BITS-1:0] height_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_CLR,
    S_IDLE,
    S_RDX,
    S_CAND,
    S_RDK,
    S_SPAN,
    S_WB,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR_INIT,
    OP_CLR_WR,
    OP_CAND,
    OP_SPAN,
    OP_WB_INIT,
    OP_WB_WR,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   rd_k;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic have;
    logic w_zero;
    logic cand_more;
    logic span_fail;
    logic span_last;
    logic wb_last;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/srp_ctrl.sv
// Sequencer for the skyline packer: clear sweep, candidate scan, span check,
// write-back and result hand-off. Depends on srp_pkg.
module srp_ctrl
  import srp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_cmd,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   boot_r, boot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    boot_nxt  = boot_r;
    case (state_r)
      S_INIT: state_nxt = S_CLR;
      S_CLR: begin
        if (stat.clr_last) begin
          state_nxt = boot_r ? S_IDLE : S_OUT;
          boot_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_cmd == CMD_CLEAR) ? S_CLR : S_RDX;
        end
      end
      S_RDX: begin
        if (stat.scan_end) begin
          state_nxt = (stat.have && !stat.w_zero) ? S_WB : S_OUT;
        end else begin
          state_nxt = S_CAND;
        end
      end
      S_CAND: state_nxt = stat.cand_more ? S_RDK : S_RDX;
      S_RDK:  state_nxt = S_SPAN;
      S_SPAN: state_nxt = (stat.span_fail || stat.span_last) ? S_RDX : S_RDK;
      S_WB:   state_nxt = stat.wb_last ? S_OUT : S_WB;
      S_OUT:  state_nxt = stat.out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_INIT;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.rd_k  = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      S_INIT: cmd.op = OP_CLR_INIT;
      S_CLR:  cmd.op = OP_CLR_WR;
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = (in_cmd == CMD_CLEAR) ? OP_CLR_INIT : OP_LOAD;
        end
      end
      S_RDX: begin
        if (stat.scan_end) begin
          cmd.op = OP_WB_INIT;
        end
      end
      S_CAND: cmd.op = OP_CAND;
      S_RDK:  cmd.rd_k = 1'b1;
      S_SPAN: cmd.op = OP_SPAN;
      S_WB:   cmd.op = OP_WB_WR;
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op = OP_OUT;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: src/srp_dpath.sv
// Datapath of the skyline packer: skyline memory, scan registers, best-fit
// tracking, write-back value and result register. Depends on srp_pkg.
module srp_dpath
  import srp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [BW_W-1:0]     item_width,
  input  logic [BW_W-1:0]     item_height,
  input  logic [CFG_AW_W-1:0] atlas_cols,
  input  logic                pad_enable,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic [POS_X_W-1:0]  out_pos_x,
  output logic [POS_Y_W-1:0]  out_pos_y
);

  height_t mem [MAX_ATLAS_WIDTH];
  height_t rd_data_r;

  logic [W_W-1:0]            w_r, hgt_r, rem_r;
  logic signed [BND_W-1:0]   bound_r;
  logic [XW-1:0]             x_r, k_r, low_x_r;
  logic                      low_vld_r, have_r;
  logic [AW-1:0]             best_x_r;
  height_t                   best_y_r, base_r, top_r;

  logic                      out_valid_r, out_found_r;
  logic [POS_X_W-1:0]        out_pos_x_r;
  logic [POS_Y_W-1:0]        out_pos_y_r;

  logic [XW-1:0]             cols;
  logic [W_W-1:0]            w_in, h_in;
  logic signed [BND_W-1:0]   bound_in;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  height_t                   wr_data;
  logic                      prune, new_low;
  logic [HEIGHT_BITS:0]      top_sum;
  height_t                   top_sat;

  // saturate the column count at the skyline depth
  always_comb begin
    if (32'(atlas_cols) > 32'(MAX_ATLAS_WIDTH)) begin
      cols = XW'(MAX_ATLAS_WIDTH);
    end else begin
      cols = XW'(atlas_cols);
    end
  end

  assign w_in     = W_W'(item_width) + W_W'(pad_enable);
  assign h_in     = W_W'(item_height) + W_W'(pad_enable);
  assign bound_in = $signed(BND_W'(cols)) - $signed(BND_W'(w_in))
                    - $signed(BND_W'(pad_enable));

  assign rd_addr = cmd.rd_k ? k_r[AW-1:0] : x_r[AW-1:0];
  assign wr_en   = (cmd.op == OP_CLR_WR) || (cmd.op == OP_WB_WR);
  assign wr_data = (cmd.op == OP_CLR_WR) ? HEIGHT_BITS'(1) : top_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[k_r[AW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign prune   = have_r && (rd_data_r >= best_y_r);
  assign new_low = (rd_data_r < base_r) && !low_vld_r;
  assign top_sum = (HEIGHT_BITS+1)'(best_y_r) + (HEIGHT_BITS+1)'(hgt_r);
  assign top_sat = top_sum[HEIGHT_BITS] ? HMAX : top_sum[HEIGHT_BITS-1:0];

  always_comb begin
    stat.scan_end  = $signed(BND_W'(x_r)) >= bound_r;
    stat.have      = have_r;
    stat.w_zero    = (w_r == '0);
    stat.cand_more = !prune && (w_r > W_W'(1));
    stat.span_fail = rd_data_r > base_r;
    stat.span_last = (rem_r == W_W'(1));
    stat.wb_last   = (rem_r == W_W'(1));
    stat.clr_last  = (k_r == XW'(MAX_ATLAS_WIDTH - 1));
    stat.out_free  = !out_valid_r || out_ready;
  end

  // scan, write-back and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        w_r      <= w_in;
        hgt_r    <= h_in;
        bound_r  <= bound_in;
        x_r      <= XW'(pad_enable);
        have_r   <= 1'b0;
        best_x_r <= '0;
        best_y_r <= '0;
      end
      OP_CLR_INIT: begin
        k_r      <= '0;
        have_r   <= 1'b0;
        best_x_r <= '0;
        best_y_r <= '0;
      end
      OP_CLR_WR: k_r <= k_r + XW'(1);
      OP_CAND: begin
        if (prune) begin
          x_r <= x_r + XW'(1);
        end else if (w_r <= W_W'(1)) begin
          // span is this column alone or empty: fits at once
          have_r   <= 1'b1;
          best_x_r <= x_r[AW-1:0];
          best_y_r <= rd_data_r;
          x_r      <= x_r + XW'(1);
        end else begin
          base_r    <= rd_data_r;
          k_r       <= x_r + XW'(1);
          rem_r     <= w_r - W_W'(1);
          low_vld_r <= 1'b0;
        end
      end
      OP_SPAN: begin
        if (rd_data_r > base_r) begin
          // every start left of the taller column fails too: jump to it
          x_r <= k_r;
        end else begin
          if (new_low) begin
            low_vld_r <= 1'b1;
            low_x_r   <= k_r;
          end
          k_r   <= k_r + XW'(1);
          rem_r <= rem_r - W_W'(1);
          if (rem_r == W_W'(1)) begin
            have_r   <= 1'b1;
            best_x_r <= x_r[AW-1:0];
            best_y_r <= base_r;
            // columns before the first lower one tie and are pruned
            if (low_vld_r) begin
              x_r <= low_x_r;
            end else if (new_low) begin
              x_r <= k_r;
            end else begin
              x_r <= k_r + XW'(1);
            end
          end
        end
      end
      OP_WB_INIT: begin
        k_r   <= XW'(best_x_r);
        rem_r <= w_r;
        top_r <= top_sat;
      end
      OP_WB_WR: begin
        k_r   <= k_r + XW'(1);
        rem_r <= rem_r - W_W'(1);
      end
      OP_OUT: begin
        out_found_r <= have_r;
        out_pos_x_r <= POS_X_W'(best_x_r);
        out_pos_y_r <= POS_Y_W'(best_y_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;

endmodule

FILE: src/skyline_rect_packer_core.sv
// Place item: each start column visited is read and then judged, each span column
// checked is read and then compared, and each column of the chosen span is raised;
// the single read port of the skyline memory sets this pace.
// Clear item: sweeps every skyline column, one column written per cycle.
// One item at a time; the next is taken while the result waits in the output register.
// Reset (rst_n low, synchronous): a clearing pass over every column, no item taken.
module skyline_rect_packer_core
  import srp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input item stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,   // block_width [8:0], block_height [17:9]
  input  logic                in_tuser,   // command
  // result item stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // pos_x [8:0], pos_y [24:9]
  output logic                out_tuser,  // found
  // configuration writes
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [CFG_AW_W-1:0] cfg_wdata
);

  logic [CFG_AW_W-1:0] atlas_cols_r;
  logic                pad_enable_r;

  dp_cmd_t             cmd;
  dp_stat_t            stat;

  logic                found;
  logic [POS_X_W-1:0]  pos_x;
  logic [POS_Y_W-1:0]  pos_y;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_cols_r <= CFG_AW_W'(512);
      pad_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ATLAS_WIDTH: atlas_cols_r <= cfg_wdata;
        REG_PAD_ENABLE:  pad_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer: walks start columns left to right, checks each span column,
  // drops a failed start straight to the taller column it hit, then raises
  // the chosen span and hands the result to the output register; a clear item sweeps the skyline.
  srp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: skyline memory with registered read, best-fit tracking and
  // the output register that parts the two stream sides.
  srp_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .item_width  (in_tdata[8:0]),
    .item_height (in_tdata[17:9]),
    .atlas_cols  (atlas_cols_r),
    .pad_enable  (pad_enable_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_found   (found),
    .out_pos_x   (pos_x),
    .out_pos_y   (pos_y)
  );

  assign out_tuser = found;
  assign out_tdata = {7'b0, pos_y, pos_x};

`ifndef SYNTHESIS
  // one item at a time: an accepted item closes the input until it is done
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // a miss or a clear carries zero coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'b0)
    else $error("result without a position has nonzero coordinates");

  // a placed block starts inside the atlas
  a_x_in_atlas: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> {1'b0, out_tdata[8:0]} < atlas_cols_r)
    else $error("placed column outside the atlas");
`endif

endmodule

FILE: verif/skyline_rect_packer_core_test.sv
// Self-checking testbench for skyline_rect_packer_core: directed table, then random phases.
// Depends on srp_pkg and the core RTL; checks use an in-bench skyline model or typed table rows.
`timescale 1ns / 100ps

module skyline_rect_packer_core_test;
  import srp_pkg::*;

  // one result item as the core reports it
  typedef struct packed {
    logic               found;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
  } placement_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one row of the directed table: either an item or a register write
  typedef struct {
    row_kind_t           kind;
    logic                reg_idx;
    logic [CFG_AW_W-1:0] reg_val;
    logic                cmd;
    logic [BW_W-1:0]     bw;
    logic [BW_W-1:0]     bh;
    bit                  typed;
    placement_t          want;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [23:0]         in_tdata;   // block_width [8:0], block_height [17:9]
  logic                in_tuser;   // command
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;  // pos_x [8:0], pos_y [24:9]
  logic                out_tuser;  // found
  logic                cfg_we;
  logic                cfg_addr;
  logic [CFG_AW_W-1:0] cfg_wdata;

  // skyline mirror and register copies used for prediction
  logic [HEIGHT_BITS-1:0] skyline_col [MAX_ATLAS_WIDTH];
  logic [CFG_AW_W-1:0]    atlas_cols_cfg;
  logic                   pad_cfg;

  placement_t placement_q [$];
  plan_row_t  plan [$];
  int         mismatch_count;
  int         send_idle_pct;
  int         recv_idle_pct;

  skyline_rect_packer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bottom-left skyline placement: lowest own height whose span is not higher,
  // leftmost on ties; raise the span and saturate at the height range. A clear resets every column.
  function automatic placement_t place_rect(logic cmd, logic [BW_W-1:0] bw,
                                            logic [BW_W-1:0] bh);
    placement_t r;
    int pad, w, h, cols, bound, x, k, best_x, best_y, top;
    bit have, fits;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      for (k = 0; k < MAX_ATLAS_WIDTH; k++) skyline_col[k] = HEIGHT_BITS'(1);
      return r;
    end
    pad = int'(pad_cfg);
    w = int'(bw) + pad;
    h = int'(bh) + pad;
    cols = int'(atlas_cols_cfg);
    if (cols > MAX_ATLAS_WIDTH) cols = MAX_ATLAS_WIDTH;
    bound = cols - w - pad;
    have = 0;
    best_x = 0;
    best_y = 0;
    for (x = pad; x < bound; x++) begin
      // skip start columns that cannot beat the current best
      if (have && int'(skyline_col[x]) >= best_y) continue;
      fits = 1;
      for (k = x; k < x + w; k++) begin
        if (skyline_col[k] > skyline_col[x]) begin
          fits = 0;
          break;
        end
      end
      if (fits) begin
        have = 1;
        best_x = x;
        best_y = int'(skyline_col[x]);
      end
    end
    if (have) begin
      top = best_y + h;
      if (top > int'(HMAX)) top = int'(HMAX);
      for (k = best_x; k < best_x + w; k++) skyline_col[k] = top[HEIGHT_BITS-1:0];
      r.found = 1'b1;
      r.pos_x = best_x[POS_X_W-1:0];
      r.pos_y = best_y[POS_Y_W-1:0];
    end
    return r;
  endfunction

  function automatic plan_row_t row_item(logic cmd, logic [BW_W-1:0] bw, logic [BW_W-1:0] bh);
    plan_row_t r;
    r = '{kind: ROW_ITEM, reg_idx: 1'b0, reg_val: '0, cmd: cmd, bw: bw, bh: bh,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t row_typed(logic cmd, logic [BW_W-1:0] bw, logic [BW_W-1:0] bh,
                                          logic f, int x, int y);
    plan_row_t r;
    r = row_item(cmd, bw, bh);
    r.typed = 1'b1;
    r.want = '{found: f, pos_x: x[POS_X_W-1:0], pos_y: y[POS_Y_W-1:0]};
    return r;
  endfunction

  function automatic plan_row_t row_cfg(logic idx, int val);
    plan_row_t r;
    r = row_item(CMD_PLACE, '0, '0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val[CFG_AW_W-1:0];
    return r;
  endfunction

  // Drop valid and hold until every expected result is back; always advances time.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (placement_q.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the core idle.
  task automatic write_reg(logic idx, logic [CFG_AW_W-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ATLAS_WIDTH) atlas_cols_cfg = val;
    else pad_cfg = val[0];
    @(posedge clk);
  endtask

  // Offer one item, hold it until accepted, then record its expected result.
  // Valid stays high on return so back-to-back items follow without a gap.
  task automatic send_item(logic cmd, logic [BW_W-1:0] bw, logic [BW_W-1:0] bh,
                           bit typed, placement_t want);
    placement_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, bh, bw};
    do @(posedge clk); while (!in_tready);
    r = place_rect(cmd, bw, bh);
    placement_q.push_back(typed ? want : r);
  endtask

  // Random items under the current registers. The tower mode stacks tall
  // one-column blocks on a two-column atlas to drive heights into saturation.
  task automatic random_items(int count, bit tower);
    int i, sel, cols, span_cap, draw;
    logic cmd;
    logic [BW_W-1:0] bw, bh;
    for (i = 0; i < count; i++) begin
      // now and then hold off until the core has emptied out
      if ($urandom_range(0, 49) == 0) drain_results();
      cols = (int'(atlas_cols_cfg) > MAX_ATLAS_WIDTH) ? MAX_ATLAS_WIDTH : int'(atlas_cols_cfg);
      span_cap = (cols / 4 < 1) ? 1 : cols / 4;
      sel = $urandom_range(0, 99);
      cmd = CMD_PLACE;
      bw = BW_W'($urandom_range(0, 511));
      bh = BW_W'($urandom_range(0, 511));
      if (tower) begin
        if (sel < 92) bw = 9'd1;
        else if (sel < 96) bw = 9'd0;
        else bw = BW_W'($urandom_range(2, 511));
        bh = BW_W'($urandom_range(400, 511));
      end else begin
        if (sel < 4) cmd = CMD_CLEAR;
        else if (sel < 74) bw = BW_W'($urandom_range(1, span_cap));
        else if (sel < 84) bw = BW_W'($urandom_range(0, 511));
        else if (sel < 90) bw = 9'd0;
        else begin
          draw = $urandom_range(span_cap, cols);
          bw = (draw > 511) ? 9'd511 : BW_W'(draw);
        end
        sel = $urandom_range(0, 99);
        if (sel < 80) bh = BW_W'($urandom_range(1, 64));
        else if (sel < 95) bh = BW_W'($urandom_range(0, 511));
        else bh = (sel[0]) ? 9'd511 : 9'd0;
      end
      send_item(cmd, bw, bh, 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure, compare each accepted item with the oldest expectation.
  initial begin
    placement_t got, want;
    out_tready = 1'b0;
    mismatch_count = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        got = '{found: out_tuser, pos_x: out_tdata[8:0], pos_y: out_tdata[24:9]};
        if (placement_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result found=%0d x=%0d y=%0d",
                   $time, got.found, got.pos_x, got.pos_y);
        end else begin
          want = placement_q.pop_front();
          if (got.found !== want.found) begin
            mismatch_count++;
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
          end
          if (got.pos_x !== want.pos_x) begin
            mismatch_count++;
            $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
          end
          if (got.pos_y !== want.pos_y) begin
            mismatch_count++;
            $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // Watchdog: far beyond the slowest legal run, even with every place at full scan length.
  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus: reset, directed table, then random phases under changing registers.
  initial begin
    int i;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 62;
    for (i = 0; i < MAX_ATLAS_WIDTH; i++) skyline_col[i] = HEIGHT_BITS'(1);
    atlas_cols_cfg = 10'd512;
    pad_cfg = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // hold off through the clearing pass that follows reset
    do @(posedge clk); while (in_tready !== 1'b1);

    // flat skyline under reset registers
    plan.push_back(row_typed(CMD_PLACE, 9'd1, 9'd1, 1'b1, 0, 1));
    plan.push_back(row_typed(CMD_CLEAR, 9'd0, 9'd0, 1'b0, 0, 0));
    plan.push_back(row_typed(CMD_PLACE, 9'd511, 9'd511, 1'b1, 0, 1));
    plan.push_back(row_typed(CMD_PLACE, 9'd511, 9'd511, 1'b1, 0, 512));
    // empty span picks the lowest column, raises nothing
    plan.push_back(row_item(CMD_PLACE, 9'd0, 9'd0));
    plan.push_back(row_item(CMD_PLACE, 9'd1, 9'd511));
    plan.push_back(row_typed(CMD_CLEAR, 9'h1FF, 9'h1FF, 1'b0, 0, 0));
    // padding: one-column margin, widths that no longer fit
    plan.push_back(row_cfg(REG_PAD_ENABLE, 1));
    plan.push_back(row_typed(CMD_PLACE, 9'd1, 9'd1, 1'b1, 1, 1));
    plan.push_back(row_typed(CMD_PLACE, 9'd510, 9'd3, 1'b0, 0, 0));
    plan.push_back(row_typed(CMD_PLACE, 9'd509, 9'd3, 1'b0, 0, 0));
    plan.push_back(row_item(CMD_PLACE, 9'd508, 9'd2));
    plan.push_back(row_item(CMD_PLACE, 9'd0, 9'd0));
    // atlas width above the column count saturates
    plan.push_back(row_cfg(REG_ATLAS_WIDTH, 1023));
    plan.push_back(row_cfg(REG_PAD_ENABLE, 0));
    plan.push_back(row_item(CMD_PLACE, 9'd511, 9'd1));
    // narrowest atlas
    plan.push_back(row_cfg(REG_ATLAS_WIDTH, 2));
    plan.push_back(row_typed(CMD_CLEAR, 9'd0, 9'd0, 1'b0, 0, 0));
    plan.push_back(row_typed(CMD_PLACE, 9'd1, 9'd5, 1'b1, 0, 1));
    plan.push_back(row_typed(CMD_PLACE, 9'd2, 9'd5, 1'b0, 0, 0));
    plan.push_back(row_item(CMD_PLACE, 9'd0, 9'd7));
    plan.push_back(row_item(CMD_PLACE, 9'd1, 9'd511));
    // full width with padding, alternating bit patterns
    plan.push_back(row_cfg(REG_ATLAS_WIDTH, 512));
    plan.push_back(row_cfg(REG_PAD_ENABLE, 1));
    plan.push_back(row_typed(CMD_PLACE, 9'd511, 9'd511, 1'b0, 0, 0));
    plan.push_back(row_item(CMD_PLACE, 9'h155, 9'h0AA));
    plan.push_back(row_item(CMD_PLACE, 9'h0AA, 9'h155));
    plan.push_back(row_typed(CMD_CLEAR, 9'h155, 9'h0AA, 1'b0, 0, 0));
    plan.push_back(row_item(CMD_PLACE, 9'd255, 9'd511));

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_item(plan[i].cmd, plan[i].bw, plan[i].bh, plan[i].typed, plan[i].want);
    end

    // sender idles more rarely than the receiver
    write_reg(REG_ATLAS_WIDTH, 10'd512);
    write_reg(REG_PAD_ENABLE, 10'd0);
    random_items(80, 1'b0);
    write_reg(REG_ATLAS_WIDTH, CFG_AW_W'($urandom_range(16, 128)));
    write_reg(REG_PAD_ENABLE, 10'd1);
    random_items(90, 1'b0);

    // swap idle rates; stack a tower into height saturation
    send_idle_pct = 62;
    recv_idle_pct = 37;
    write_reg(REG_ATLAS_WIDTH, 10'd2);
    write_reg(REG_PAD_ENABLE, 10'd0);
    send_item(CMD_CLEAR, 9'd0, 9'd0, 1'b0, '0);
    random_items(166, 1'b1);
    write_reg(REG_ATLAS_WIDTH, 10'd300);
    write_reg(REG_PAD_ENABLE, 10'd1);
    random_items(80, 1'b0);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_ATLAS_WIDTH, CFG_AW_W'($urandom_range(2, 512)));
    write_reg(REG_PAD_ENABLE, 10'd0);
    random_items(60, 1'b0);
    write_reg(REG_ATLAS_WIDTH, 10'd1023);
    write_reg(REG_PAD_ENABLE, 10'd1);
    random_items(20, 1'b0);
    write_reg(REG_ATLAS_WIDTH, 10'd511);
    write_reg(REG_PAD_ENABLE, 10'd0);
    random_items(20, 1'b0);

    // wait out outstanding results, then a full scan length for strays
    drain_results();
    repeat (4 * MAX_ATLAS_WIDTH) @(posedge clk);
    if (mismatch_count == 0 && placement_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: skyline_rect_packer_core.f
src/srp_pkg.sv
src/srp_ctrl.sv
src/srp_dpath.sv
src/skyline_rect_packer_core.sv
verif/skyline_rect_packer_core_test.sv
